/* rtl/core/assert_macros.svh */
// Shared assertion macros for the rotor cipher core.
// All checks run on the rising clock edge and are held off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational or same-cycle property.
`define RCLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent this edge, consequent at the next edge.
`define RCLS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/rcls_pkg.sv */
`default_nettype none

package rcls_pkg;

  typedef logic [4:0] letter_t;
  typedef logic [1:0] wsel_t;

  localparam letter_t LETTERS     = 5'd26;
  localparam letter_t LAST_LETTER = 5'd25;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 50;
  localparam int unsigned CHOICE_W   = 2;
  localparam int unsigned PACK_W     = 15;
  localparam int unsigned PLUG_W     = 50;
  localparam int unsigned NUM_PAIRS  = 10;
  localparam int unsigned PAIR_W     = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_CHOICE,
    CFG_MIDDLE_CHOICE,
    CFG_RIGHT_CHOICE,
    CFG_RING_OFFSETS,
    CFG_START_POSITIONS,
    CFG_PLUG_LOW,
    CFG_PLUG_HIGH
  } cfg_idx_e;

  // Rotor wirings I, II, III, entry to exit.
  localparam letter_t FWD_TAB [3][26] = '{
    '{5'd4, 5'd10, 5'd12, 5'd5, 5'd11, 5'd6, 5'd3, 5'd16, 5'd21, 5'd25, 5'd13, 5'd19,
      5'd14, 5'd22, 5'd24, 5'd7, 5'd23, 5'd20, 5'd18, 5'd15, 5'd0, 5'd8, 5'd1, 5'd17,
      5'd2, 5'd9},
    '{5'd0, 5'd9, 5'd3, 5'd10, 5'd18, 5'd8, 5'd17, 5'd20, 5'd23, 5'd1, 5'd11, 5'd7,
      5'd22, 5'd19, 5'd12, 5'd2, 5'd16, 5'd6, 5'd25, 5'd13, 5'd15, 5'd24, 5'd5, 5'd21,
      5'd14, 5'd4},
    '{5'd1, 5'd3, 5'd5, 5'd7, 5'd9, 5'd11, 5'd2, 5'd15, 5'd17, 5'd19, 5'd23, 5'd21,
      5'd25, 5'd13, 5'd24, 5'd4, 5'd8, 5'd22, 5'd6, 5'd0, 5'd10, 5'd12, 5'd20, 5'd18,
      5'd16, 5'd14}
  };

  // Inverse wirings for the return path.
  localparam letter_t BACK_TAB [3][26] = '{
    '{5'd20, 5'd22, 5'd24, 5'd6, 5'd0, 5'd3, 5'd5, 5'd15, 5'd21, 5'd25, 5'd1, 5'd4,
      5'd2, 5'd10, 5'd12, 5'd19, 5'd7, 5'd23, 5'd18, 5'd11, 5'd17, 5'd8, 5'd13, 5'd16,
      5'd14, 5'd9},
    '{5'd0, 5'd9, 5'd15, 5'd2, 5'd25, 5'd22, 5'd17, 5'd11, 5'd5, 5'd1, 5'd3, 5'd10,
      5'd14, 5'd19, 5'd24, 5'd20, 5'd16, 5'd6, 5'd4, 5'd13, 5'd7, 5'd23, 5'd12, 5'd8,
      5'd21, 5'd18},
    '{5'd19, 5'd0, 5'd6, 5'd1, 5'd15, 5'd2, 5'd18, 5'd3, 5'd16, 5'd4, 5'd20, 5'd5,
      5'd21, 5'd13, 5'd25, 5'd7, 5'd24, 5'd8, 5'd23, 5'd9, 5'd22, 5'd11, 5'd17, 5'd10,
      5'd14, 5'd12}
  };

  localparam letter_t REFLECT_TAB [26] = '{
    5'd24, 5'd17, 5'd20, 5'd7, 5'd16, 5'd18, 5'd11, 5'd3, 5'd15, 5'd23, 5'd13, 5'd6,
    5'd14, 5'd10, 5'd12, 5'd8, 5'd4, 5'd1, 5'd5, 5'd25, 5'd2, 5'd22, 5'd21, 5'd9,
    5'd0, 5'd19
  };

  // Turnover notches Q, E, V.
  localparam letter_t NOTCH [3] = '{5'd16, 5'd4, 5'd21};

  typedef struct packed {
    wsel_t               wl;
    wsel_t               wm;
    wsel_t               wr;
    letter_t             ring_l;
    letter_t             ring_m;
    letter_t             ring_r;
    letter_t             start_l;
    letter_t             start_m;
    letter_t             start_r;
    logic [PLUG_W-1:0]   plug_lo;
    logic [PLUG_W-1:0]   plug_hi;
  } rotor_cfg_t;

  typedef struct packed {
    letter_t letter;
    letter_t pos_l;
    letter_t pos_m;
    letter_t pos_r;
  } beat_t;

  function automatic letter_t mod_inc(letter_t x);
    return (x == LAST_LETTER) ? 5'd0 : x + 5'd1;
  endfunction

  function automatic letter_t mod_add(letter_t a, letter_t b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, LETTERS}) ? letter_t'(s - {1'b0, LETTERS}) : letter_t'(s);
  endfunction

  function automatic letter_t mod_sub(letter_t a, letter_t b);
    logic [5:0] d;
    d = {1'b0, a} + {1'b0, LETTERS} - {1'b0, b};
    return (a >= b) ? a - b : letter_t'(d);
  endfunction

  function automatic letter_t clamp_letter(letter_t v);
    return (v > LAST_LETTER) ? LAST_LETTER : v;
  endfunction

  // 26..31 fold onto 0..5
  function automatic letter_t wrap_letter(letter_t v);
    return (v > LAST_LETTER) ? v - LETTERS : v;
  endfunction

  function automatic wsel_t wiring_index(logic [CHOICE_W-1:0] c);
    return (c == 2'd0) ? 2'd0 : c - 2'd1;
  endfunction

  function automatic letter_t rotor_fwd(wsel_t w, letter_t x, letter_t shift);
    letter_t t;
    t = mod_add(x, shift);
    return mod_sub(FWD_TAB[w][t], shift);
  endfunction

  function automatic letter_t rotor_back(wsel_t w, letter_t x, letter_t shift);
    letter_t t;
    t = mod_add(x, shift);
    return mod_sub(BACK_TAB[w][t], shift);
  endfunction

  // Last valid pair touching x wins; within a pair the b side is written last.
  function automatic letter_t plug_map(logic [PLUG_W-1:0] lo, logic [PLUG_W-1:0] hi,
                                       letter_t x);
    logic [2*PLUG_W-1:0] all;
    letter_t             a;
    letter_t             b;
    letter_t             r;
    int unsigned         k;
    all = {hi, lo};
    r   = x;
    for (k = 0; k < NUM_PAIRS; k++) begin
      a = all[PAIR_W*k +: 5];
      b = all[PAIR_W*k+5 +: 5];
      if (a != b && a <= LAST_LETTER && b <= LAST_LETTER) begin
        if (b == x) begin
          r = a;
        end else if (a == x) begin
          r = b;
        end
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/rcls_if.sv */
`default_nettype none

interface rcls_in_if;
  logic              valid;
  logic              ready;
  rcls_pkg::letter_t plain_letter;
  logic              restart;

  modport source (output valid, output plain_letter, output restart, input ready);
  modport sink   (input valid, input plain_letter, input restart, output ready);
endinterface

interface rcls_out_if;
  logic              valid;
  logic              ready;
  rcls_pkg::letter_t cipher_letter;
  rcls_pkg::letter_t left_position;
  rcls_pkg::letter_t middle_position;
  rcls_pkg::letter_t right_position;

  modport source (output valid, output cipher_letter, output left_position,
                  output middle_position, output right_position, input ready);
  modport sink   (input valid, input cipher_letter, input left_position,
                  input middle_position, input right_position, output ready);
endinterface

interface rcls_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rcls_pkg::CFG_IDX_W-1:0]      index;
  logic [rcls_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/rcls_cfg.sv */
`default_nettype none

module rcls_cfg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  rcls_cfg_if.sink             cfg_i,
  output rcls_pkg::rotor_cfg_t rcfg_o
);

  logic [rcls_pkg::CHOICE_W-1:0] left_choice_q;
  logic [rcls_pkg::CHOICE_W-1:0] middle_choice_q;
  logic [rcls_pkg::CHOICE_W-1:0] right_choice_q;
  logic [rcls_pkg::PACK_W-1:0]   ring_q;
  logic [rcls_pkg::PACK_W-1:0]   start_q;
  logic [rcls_pkg::PLUG_W-1:0]   plug_lo_q;
  logic [rcls_pkg::PLUG_W-1:0]   plug_hi_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_choice_q   <= 2'd1;
      middle_choice_q <= 2'd2;
      right_choice_q  <= 2'd3;
      ring_q          <= '0;
      start_q         <= '0;
      plug_lo_q       <= '0;
      plug_hi_q       <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        rcls_pkg::CFG_LEFT_CHOICE:     left_choice_q   <= cfg_i.data[rcls_pkg::CHOICE_W-1:0];
        rcls_pkg::CFG_MIDDLE_CHOICE:   middle_choice_q <= cfg_i.data[rcls_pkg::CHOICE_W-1:0];
        rcls_pkg::CFG_RIGHT_CHOICE:    right_choice_q  <= cfg_i.data[rcls_pkg::CHOICE_W-1:0];
        rcls_pkg::CFG_RING_OFFSETS:    ring_q          <= cfg_i.data[rcls_pkg::PACK_W-1:0];
        rcls_pkg::CFG_START_POSITIONS: start_q         <= cfg_i.data[rcls_pkg::PACK_W-1:0];
        rcls_pkg::CFG_PLUG_LOW:        plug_lo_q       <= cfg_i.data[rcls_pkg::PLUG_W-1:0];
        rcls_pkg::CFG_PLUG_HIGH:       plug_hi_q       <= cfg_i.data[rcls_pkg::PLUG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    rcfg_o.wl      = rcls_pkg::wiring_index(left_choice_q);
    rcfg_o.wm      = rcls_pkg::wiring_index(middle_choice_q);
    rcfg_o.wr      = rcls_pkg::wiring_index(right_choice_q);
    rcfg_o.ring_l  = rcls_pkg::clamp_letter(ring_q[14:10]);
    rcfg_o.ring_m  = rcls_pkg::clamp_letter(ring_q[9:5]);
    rcfg_o.ring_r  = rcls_pkg::clamp_letter(ring_q[4:0]);
    rcfg_o.start_l = rcls_pkg::clamp_letter(start_q[14:10]);
    rcfg_o.start_m = rcls_pkg::clamp_letter(start_q[9:5]);
    rcfg_o.start_r = rcls_pkg::clamp_letter(start_q[4:0]);
    rcfg_o.plug_lo = plug_lo_q;
    rcfg_o.plug_hi = plug_hi_q;
  end

endmodule

`default_nettype wire

/* rtl/core/rcls_step.sv */
`default_nettype none

`include "assert_macros.svh"

module rcls_step (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  rcls_in_if.sink              in_i,
  input  rcls_pkg::rotor_cfg_t rcfg_i,
  output logic                 s0_valid_o,
  input  wire                  s0_ready_i,
  output rcls_pkg::beat_t      s0_beat_o
);

  rcls_pkg::letter_t pos_l_q, pos_m_q, pos_r_q;
  rcls_pkg::letter_t pos_l_d, pos_m_d, pos_r_d;
  rcls_pkg::letter_t base_l, base_m, base_r;
  logic              carry, mid_notch, acc;
  logic              s0_valid_q;
  rcls_pkg::beat_t   s0_beat_q;

  assign in_i.ready = !s0_valid_q || s0_ready_i;
  assign acc        = in_i.valid && in_i.ready;

  // Notch tests use the positions held before this step (middle double-steps).
  always_comb begin
    base_l    = in_i.restart ? rcfg_i.start_l : pos_l_q;
    base_m    = in_i.restart ? rcfg_i.start_m : pos_m_q;
    base_r    = in_i.restart ? rcfg_i.start_r : pos_r_q;
    carry     = (base_r == rcls_pkg::NOTCH[rcfg_i.wr]);
    mid_notch = (base_m == rcls_pkg::NOTCH[rcfg_i.wm]);
    pos_r_d   = rcls_pkg::mod_inc(base_r);
    pos_m_d   = (carry || mid_notch) ? rcls_pkg::mod_inc(base_m) : base_m;
    pos_l_d   = mid_notch ? rcls_pkg::mod_inc(base_l) : base_l;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_l_q    <= '0;
      pos_m_q    <= '0;
      pos_r_q    <= '0;
      s0_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        pos_l_q <= pos_l_d;
        pos_m_q <= pos_m_d;
        pos_r_q <= pos_r_d;
      end
      if (acc) begin
        s0_valid_q <= 1'b1;
      end else if (s0_ready_i) begin
        s0_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s0_beat_q.letter <= rcls_pkg::wrap_letter(in_i.plain_letter);
      s0_beat_q.pos_l  <= pos_l_d;
      s0_beat_q.pos_m  <= pos_m_d;
      s0_beat_q.pos_r  <= pos_r_d;
    end
  end

  assign s0_valid_o = s0_valid_q;
  assign s0_beat_o  = s0_beat_q;

  `RCLS_ASSERT_NEXT(a_right_advances, clk_i, rst_ni, acc && !in_i.restart,
    pos_r_q == rcls_pkg::mod_inc($past(pos_r_q)), "fast rotor did not advance by one")
  `RCLS_ASSERT(a_pos_range, clk_i, rst_ni,
    pos_l_q <= rcls_pkg::LAST_LETTER && pos_m_q <= rcls_pkg::LAST_LETTER &&
    pos_r_q <= rcls_pkg::LAST_LETTER, "rotor position out of range")

endmodule

`default_nettype wire

/* rtl/core/rcls_fwd.sv */
`default_nettype none

`include "assert_macros.svh"

module rcls_fwd (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rcls_pkg::rotor_cfg_t rcfg_i,
  input  wire                  s0_valid_i,
  output logic                 s0_ready_o,
  input  rcls_pkg::beat_t      s0_beat_i,
  output logic                 s1_valid_o,
  input  wire                  s1_ready_i,
  output rcls_pkg::beat_t      s1_beat_o
);

  rcls_pkg::letter_t x_plug, x_r, x_m, x_l, x_refl;
  logic              s1_valid_q;
  rcls_pkg::beat_t   s1_beat_q;
  logic              load;

  assign s0_ready_o = !s1_valid_q || s1_ready_i;
  assign load       = s0_valid_i && s0_ready_o;

  // Plugboard, right-middle-left entry path, reflector.
  always_comb begin
    x_plug = rcls_pkg::plug_map(rcfg_i.plug_lo, rcfg_i.plug_hi, s0_beat_i.letter);
    x_r    = rcls_pkg::rotor_fwd(rcfg_i.wr, x_plug,
                                 rcls_pkg::mod_sub(s0_beat_i.pos_r, rcfg_i.ring_r));
    x_m    = rcls_pkg::rotor_fwd(rcfg_i.wm, x_r,
                                 rcls_pkg::mod_sub(s0_beat_i.pos_m, rcfg_i.ring_m));
    x_l    = rcls_pkg::rotor_fwd(rcfg_i.wl, x_m,
                                 rcls_pkg::mod_sub(s0_beat_i.pos_l, rcfg_i.ring_l));
    x_refl = rcls_pkg::REFLECT_TAB[x_l];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (load) begin
      s1_valid_q <= 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_beat_q.letter <= x_refl;
      s1_beat_q.pos_l  <= s0_beat_i.pos_l;
      s1_beat_q.pos_m  <= s0_beat_i.pos_m;
      s1_beat_q.pos_r  <= s0_beat_i.pos_r;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_beat_o  = s1_beat_q;

  `RCLS_ASSERT(a_mid_letter_range, clk_i, rst_ni,
    !s1_valid_q || s1_beat_q.letter <= rcls_pkg::LAST_LETTER, "reflected letter out of range")

endmodule

`default_nettype wire

/* rtl/core/rcls_back.sv */
`default_nettype none

`include "assert_macros.svh"

module rcls_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  rcls_pkg::rotor_cfg_t rcfg_i,
  input  wire                  s1_valid_i,
  output logic                 s1_ready_o,
  input  rcls_pkg::beat_t      s1_beat_i,
  rcls_out_if.source           out_o
);

  rcls_pkg::letter_t x_l, x_m, x_r, x_plug;
  logic              res_valid_q;
  rcls_pkg::beat_t   res_q;
  logic              load;

  assign s1_ready_o = !res_valid_q || out_o.ready;
  assign load       = s1_valid_i && s1_ready_o;

  // Return path left-middle-right through inverse wirings, then plugboard.
  always_comb begin
    x_l    = rcls_pkg::rotor_back(rcfg_i.wl, s1_beat_i.letter,
                                  rcls_pkg::mod_sub(s1_beat_i.pos_l, rcfg_i.ring_l));
    x_m    = rcls_pkg::rotor_back(rcfg_i.wm, x_l,
                                  rcls_pkg::mod_sub(s1_beat_i.pos_m, rcfg_i.ring_m));
    x_r    = rcls_pkg::rotor_back(rcfg_i.wr, x_m,
                                  rcls_pkg::mod_sub(s1_beat_i.pos_r, rcfg_i.ring_r));
    x_plug = rcls_pkg::plug_map(rcfg_i.plug_lo, rcfg_i.plug_hi, x_r);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (load) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q.letter <= x_plug;
      res_q.pos_l  <= s1_beat_i.pos_l;
      res_q.pos_m  <= s1_beat_i.pos_m;
      res_q.pos_r  <= s1_beat_i.pos_r;
    end
  end

  assign out_o.valid           = res_valid_q;
  assign out_o.cipher_letter   = res_q.letter;
  assign out_o.left_position   = res_q.pos_l;
  assign out_o.middle_position = res_q.pos_m;
  assign out_o.right_position  = res_q.pos_r;

  `RCLS_ASSERT(a_cipher_range, clk_i, rst_ni,
    !res_valid_q || res_q.letter <= rcls_pkg::LAST_LETTER, "cipher letter out of range")

endmodule

`default_nettype wire

/* rtl/core/rotor_cipher_letter_step.sv */
`default_nettype none

// Three-rotor letter cipher (wirings I/II/III, reflector B, ten-pair plugboard).
// One letter is accepted per clock unless the output stalls; the rotors step in
// the accept cycle, so the next letter can follow immediately and sustained
// throughput is one letter per cycle. Each letter passes through the registers
// in order: the step register is loaded at the edge that accepts it, then the
// register after the plugboard, entry rotors and reflector, then the result
// register after the return rotors and plugboard. Each of the three stages
// holds its beat while the stage after it is full and stalled. The
// configuration port is always ready and each write is registered; writes are
// meant for when no letters are in flight.
module rotor_cipher_letter_step (
  input  wire        clk_i,
  input  wire        rst_ni,
  rcls_cfg_if.sink   cfg_i,
  rcls_in_if.sink    in_i,
  rcls_out_if.source out_o
);

  rcls_pkg::rotor_cfg_t rcfg;
  logic                 s0_valid, s0_ready;
  rcls_pkg::beat_t      s0_beat;
  logic                 s1_valid, s1_ready;
  rcls_pkg::beat_t      s1_beat;

  rcls_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .rcfg_o (rcfg)
  );

  rcls_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .rcfg_i     (rcfg),
    .s0_valid_o (s0_valid),
    .s0_ready_i (s0_ready),
    .s0_beat_o  (s0_beat)
  );

  rcls_fwd u_fwd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rcfg_i     (rcfg),
    .s0_valid_i (s0_valid),
    .s0_ready_o (s0_ready),
    .s0_beat_i  (s0_beat),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_beat_o  (s1_beat)
  );

  rcls_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rcfg_i     (rcfg),
    .s1_valid_i (s1_valid),
    .s1_ready_o (s1_ready),
    .s1_beat_i  (s1_beat),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire
